// ===== design/battery_level_monitor_defines.svh =====
// Assertion macros shared by the battery level monitor RTL.
`ifndef BATTERY_LEVEL_MONITOR_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/blm_pkg.sv =====
// Constants, discharge curve and types for the battery level monitor.
package blm_pkg;

    // Field widths
    localparam int PIN_W    = 12;
    localparam int MV_W     = 13;
    localparam int GAIN_W   = 16;
    localparam int HYST_W   = 10;
    localparam int CHARGE_W = 15;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    // Limits
    localparam logic [MV_W-1:0]     MV_MAX    = 13'd8191;
    localparam logic [CHARGE_W-1:0] Q8_FULL   = 15'd25600;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Reciprocal scale: quotient = (num * recip) >> RECIP_SHIFT, exact floor
    // for num below 2^17 and spans up to 200
    localparam int RECIP_SHIFT = 26;
    localparam int QUOT_W      = 12;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVIDER_GAIN     = 4'd0,
        REG_TRANSMIT_CUTOFF  = 4'd1,
        REG_HYSTERESIS       = 4'd2,
        REG_SLEEP_CUTOFF     = 4'd3
    } cfg_reg_t;

    // Discharge curve, highest voltage first
    localparam int CURVE_POINTS = 20;
    localparam int IDX_W        = $clog2(CURVE_POINTS);

    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd4200, 13'd4150, 13'd4100, 13'd4050, 13'd4000,
        13'd3950, 13'd3900, 13'd3850, 13'd3800, 13'd3750,
        13'd3700, 13'd3650, 13'd3600, 13'd3550, 13'd3500,
        13'd3450, 13'd3400, 13'd3300, 13'd3200, 13'd3000
    };

    localparam logic [7:0] CURVE_PCT [CURVE_POINTS] = '{
        8'd100, 8'd95, 8'd90, 8'd85, 8'd78,
        8'd70,  8'd62, 8'd55, 8'd48, 8'd42,
        8'd35,  8'd28, 8'd22, 8'd17, 8'd12,
        8'd8,   8'd5,  8'd2,  8'd1,  8'd0
    };

    // ceil(2^26 / span) for each segment, indexed by its upper point
    localparam logic [MUL_B_W-1:0] SEG_RECIP [CURVE_POINTS-1] = '{
        21'd1342178, 21'd1342178, 21'd1342178, 21'd1342178, 21'd1342178,
        21'd1342178, 21'd1342178, 21'd1342178, 21'd1342178, 21'd1342178,
        21'd1342178, 21'd1342178, 21'd1342178, 21'd1342178, 21'd1342178,
        21'd1342178, 21'd671089,  21'd671089,  21'd335545
    };

endpackage

// ===== design/battery_level_monitor.sv =====
// Battery level monitor: pin voltage to battery mV, charge percent and flags.
//
// Input channel s_*: one item per reading, pin millivolts in s_tdata and the
// USB-attached flag in s_tuser. Output channel m_*: one result item per input
// item, battery millivolts and Q8 charge percent in m_tdata, the trustworthy,
// critical and transmit flags in m_tuser. Configuration channel cfg_*: four
// registers (divider gain, transmit cutoff, hysteresis, sleep cutoff), always
// ready, to be written only while no item is in flight.
//
// One item at a time. An accepted input passes the scale, segment, slope and
// reciprocal states before the result is valid; a single 17x21 multiplier is
// used three times in sequence (gain scaling, interpolation slope, reciprocal
// divide), with the curve segment search in its own state. s_tready returns
// the cycle after the result is taken, so no new item enters before that.
//
// A stalled receiver holds the result in the output registers and keeps
// s_tready low. Reset restores the register defaults, sets the previous
// transmit verdict to allowed and empties the block.
`include "battery_level_monitor_defines.svh"

module battery_level_monitor #(
    parameter int GAIN_FRACTION_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,

    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] pin_millivolts
    input  logic        s_tuser,   // [0] usb_attached

    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [12:0] battery_millivolts, [27:13] charge_percent_q8
    output logic [2:0]  m_tuser,   // [0] trustworthy, [1] critical, [2] transmit_allowed

    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [blm_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SEG,
        ST_SLOPE,
        ST_RECIP,
        ST_OUT
    } state_t;

    // Configuration registers
    logic [blm_pkg::GAIN_W-1:0] gain_reg;
    logic [blm_pkg::MV_W-1:0]   tx_cutoff_reg;
    logic [blm_pkg::HYST_W-1:0] hyst_reg;
    logic [blm_pkg::MV_W-1:0]   sleep_cutoff_reg;

    // Sequencer and working registers
    state_t                          state_reg;
    logic [blm_pkg::PIN_W-1:0]       pin_reg;
    logic                            usb_reg;
    logic                            verdict_reg;
    logic [blm_pkg::MV_W-1:0]        mv_reg;
    logic [blm_pkg::IDX_W-1:0]       lo_idx_reg;
    logic [blm_pkg::MV_W-1:0]        d_reg;
    logic [blm_pkg::MUL_A_W-1:0]     num_reg;
    logic                            full_reg;
    logic                            empty_reg;
    logic                            crit_reg;
    logic                            tx_reg;
    logic [blm_pkg::CHARGE_W-1:0]    charge_reg;

    // Shared multiplier
    logic [blm_pkg::MUL_A_W-1:0] mul_a;
    logic [blm_pkg::MUL_B_W-1:0] mul_b;
    logic [blm_pkg::PROD_W-1:0]  prod;

    // Derived values
    logic [blm_pkg::PROD_W-1:0]   scaled_full;
    logic [blm_pkg::MV_W-1:0]     mv_next;
    logic [blm_pkg::IDX_W-1:0]    lo_idx_next;
    logic [blm_pkg::IDX_W-1:0]    hi_idx;
    logic [blm_pkg::MV_W:0]       threshold;
    logic                         tx_next;
    logic [7:0]                   dp_pct;
    logic [blm_pkg::QUOT_W-1:0]   quot;
    logic [16:0]                  charge_sum;
    logic [blm_pkg::CHARGE_W-1:0] charge_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {4'd0, charge_reg, mv_reg};
    assign m_tuser   = {tx_reg, crit_reg, ~usb_reg};

    // Segment bounds of the latched voltage
    assign hi_idx = lo_idx_reg - blm_pkg::IDX_W'(1);
    assign dp_pct = blm_pkg::CURVE_PCT[hi_idx] - blm_pkg::CURVE_PCT[lo_idx_reg];

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_SCALE:
            begin
                mul_a = blm_pkg::MUL_A_W'(pin_reg);
                mul_b = blm_pkg::MUL_B_W'(gain_reg);
            end
            ST_SLOPE:
            begin
                mul_a = blm_pkg::MUL_A_W'(d_reg);
                mul_b = blm_pkg::MUL_B_W'({dp_pct, 8'd0});
            end
            ST_RECIP:
            begin
                mul_a = num_reg;
                mul_b = blm_pkg::SEG_RECIP[hi_idx];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = blm_pkg::PROD_W'(mul_a) * blm_pkg::PROD_W'(mul_b);

    // Gain scaling with saturation
    assign scaled_full = prod >> GAIN_FRACTION_BITS;
    assign mv_next = (|scaled_full[blm_pkg::PROD_W-1:blm_pkg::MV_W]) ? blm_pkg::MV_MAX
                                                                   : scaled_full[blm_pkg::MV_W-1:0];

    // Curve search: lowest point still above the voltage bounds the segment
    always_comb
    begin
        lo_idx_next = blm_pkg::IDX_W'(1);
        for (int i = 1; i < blm_pkg::CURVE_POINTS - 1; i++)
        begin
            if (mv_reg < blm_pkg::CURVE_MV[i])
            begin
                lo_idx_next = blm_pkg::IDX_W'(i + 1);
            end
        end
    end

    // Transmit with hysteresis on the previous verdict
    assign threshold = verdict_reg ? {1'b0, tx_cutoff_reg}
                                   : {1'b0, tx_cutoff_reg} + (blm_pkg::MV_W + 1)'(hyst_reg);
    assign tx_next   = usb_reg || ({1'b0, mv_reg} >= threshold);

    // Interpolated charge, clamped
    assign quot       = prod[blm_pkg::RECIP_SHIFT +: blm_pkg::QUOT_W];
    assign charge_sum = {1'b0, blm_pkg::CURVE_PCT[lo_idx_reg], 8'd0} + 17'(quot);
    always_comb
    begin
        priority if (full_reg)
        begin
            charge_next = blm_pkg::Q8_FULL;
        end
        else if (empty_reg)
        begin
            charge_next = '0;
        end
        else if (charge_sum > 17'(blm_pkg::Q8_FULL))
        begin
            charge_next = blm_pkg::Q8_FULL;
        end
        else
        begin
            charge_next = charge_sum[blm_pkg::CHARGE_W-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg         <= 16'd8192;
            tx_cutoff_reg    <= 13'd3500;
            hyst_reg         <= 10'd50;
            sleep_cutoff_reg <= 13'd3300;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                blm_pkg::REG_DIVIDER_GAIN:    gain_reg         <= cfg_data;
                blm_pkg::REG_TRANSMIT_CUTOFF: tx_cutoff_reg    <= cfg_data[blm_pkg::MV_W-1:0];
                blm_pkg::REG_HYSTERESIS:      hyst_reg         <= cfg_data[blm_pkg::HYST_W-1:0];
                blm_pkg::REG_SLEEP_CUTOFF:    sleep_cutoff_reg <= cfg_data[blm_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b1;
            pin_reg     <= '0;
            usb_reg     <= 1'b0;
            mv_reg      <= '0;
            lo_idx_reg  <= blm_pkg::IDX_W'(1);
            d_reg       <= '0;
            num_reg     <= '0;
            full_reg    <= 1'b0;
            empty_reg   <= 1'b0;
            crit_reg    <= 1'b0;
            tx_reg      <= 1'b0;
            charge_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        pin_reg   <= s_tdata[blm_pkg::PIN_W-1:0];
                        usb_reg   <= s_tuser;
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    mv_reg    <= mv_next;
                    state_reg <= ST_SEG;
                end
                ST_SEG:
                begin
                    lo_idx_reg  <= lo_idx_next;
                    d_reg       <= mv_reg - blm_pkg::CURVE_MV[lo_idx_next];
                    full_reg    <= (mv_reg >= blm_pkg::CURVE_MV[0]);
                    empty_reg   <= (mv_reg <= blm_pkg::CURVE_MV[blm_pkg::CURVE_POINTS-1]);
                    crit_reg    <= (mv_reg < sleep_cutoff_reg) && !usb_reg;
                    tx_reg      <= tx_next;
                    verdict_reg <= tx_next;
                    state_reg   <= ST_SLOPE;
                end
                ST_SLOPE:
                begin
                    num_reg   <= prod[blm_pkg::MUL_A_W-1:0];
                    state_reg <= ST_RECIP;
                end
                ST_RECIP:
                begin
                    charge_reg <= charge_next;
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `BLM_ASSERT_NOW(a_one_side_open, s_tready, !m_tvalid, "input open while result pending")
    `BLM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !m_tvalid,
                     "block not busy after accept")
    `BLM_ASSERT_NOW(a_charge_range, m_tvalid, m_tdata[27:13] <= blm_pkg::Q8_FULL,
                    "charge above full scale")
    `BLM_ASSERT_NOW(a_usb_flags, m_tvalid && !m_tuser[0], m_tuser[2] && !m_tuser[1],
                    "USB reading must transmit and not be critical")

endmodule
